>>> hw/rtl/tqwtd_pkg.sv
// ----------------------------------------------------------------------------
// Ticket dispatcher package
// Shared field widths, function and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tqwtd_pkg;

   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned MINUTE_W = 11;
   localparam int unsigned NUMBER_W = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned WEIGHT_W = 4;
   localparam int unsigned ENTRY_W  = NUMBER_W + MINUTE_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd2;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_ISSUE_NORMAL = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ISSUE_PREF   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CALL         = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_ISSUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CALLED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   localparam logic CLASS_NORMAL = 1'b0;
   localparam logic CLASS_PREF   = 1'b1;

   // Controller to datapath.
   typedef struct packed {
      logic capture;    // latch the request fields
      logic execute;    // carry out the latched request
      logic load_fetch; // move the popped queue entry into the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic nop;        // latched request has an unused function code
      logic pops;       // latched request reads a queue entry
      logic out_busy;   // output register still holds an item not taken
   } stat_type;

endpackage

>>> hw/rtl/two_queue_weighted_ticket_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// Two-queue weighted ticket dispatcher
// Issues and calls tickets of a normal and a preferential class, serving by
// weighted round robin while both queues wait.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is latched, then executed once the output
//    register is free. An issue item or an empty call loads its result into
//    the output register on execution; a call that pops a ticket loads it in
//    a further fetch step, from the registered read of the queue memory.
//    The controller takes no new item until it is through with the last one.
// Reset: synchronous and active high. Queues empty, ticket counters and the
//    weight counter cleared, normal_per_preferential set to 2. Queue memories
//    are not cleared; entries are always written before they are read.
module two_queue_weighted_ticket_dispatcher_unit
   import tqwtd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
)
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [10:0] arrival_minute, [15:11] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] ticket_class, [16:1] ticket_number,
                                    // [27:17] ticket_minute, [31:28] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Configuration: normal_per_preferential.
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   cmd_type             cmd;
   stat_type            stat;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_class;
   logic [NUMBER_W-1:0] rsp_number;
   logic [MINUTE_W-1:0] rsp_minute;

   // The controller sequences each item; it accepts a new item while the
   // previous result still waits in the output register, and holds the item
   // before execution until that register is free.
   tqwtd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds both queues, the counters and the output register.
   tqwtd_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_func    (req_tuser),
      .req_minute  (req_tdata[MINUTE_W-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_status  (rsp_status),
      .rsp_class   (rsp_class),
      .rsp_number  (rsp_number),
      .rsp_minute  (rsp_minute)
   );

   // Pack the result fields, lowest field first, zero filled to 32 bits.
   assign rsp_tdata = {4'b0000, rsp_minute, rsp_number, rsp_class};
   assign rsp_tuser = rsp_status;

endmodule

>>> hw/rtl/tqwtd_ctrl.sv
// ----------------------------------------------------------------------------
// Ticket dispatcher controller
// Sequences one request at a time: capture, execute (skipped for an unused
// function code), and a fetch step when a queue entry is read from memory.
// ----------------------------------------------------------------------------
module tqwtd_ctrl
   import tqwtd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FETCH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.execute    = 1'b0;
      cmd.load_fetch = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.nop) begin
               state_in = ST_IDLE;
            end else if (!stat.out_busy) begin
               cmd.execute = 1'b1;
               state_in    = stat.pops ? ST_FETCH : ST_IDLE;
            end
         end
         ST_FETCH: begin
            cmd.load_fetch = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/tqwtd_datapath.sv
// ----------------------------------------------------------------------------
// Ticket dispatcher datapath
// Two ticket FIFOs in memory, ticket counters, the weight counter, the
// configuration register and the output register.
// ----------------------------------------------------------------------------
module tqwtd_datapath
   import tqwtd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [MINUTE_W-1:0] req_minute,
   input  logic                csr_wr_en,
   input  logic [WEIGHT_W-1:0] csr_wr_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_class,
   output logic [NUMBER_W-1:0] rsp_number,
   output logic [MINUTE_W-1:0] rsp_minute
);

   localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_EXT  = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);

   // Storage.
   logic [ENTRY_W-1:0] n_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] p_mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] n_rdata_ff;
   logic [ENTRY_W-1:0] p_rdata_ff;

   // Control and queue state.
   logic [IDX_W-1:0]    n_head_ff, p_head_ff;
   logic [CNT_W-1:0]    n_count_ff, p_count_ff;
   logic [NUMBER_W-1:0] n_ticket_ff, p_ticket_ff;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [WEIGHT_W-1:0] npp_ff;
   logic                out_valid_ff;
   logic                pop_class_ff;

   // Latched request and output payload.
   logic [FUNC_W-1:0]   func_ff;
   logic [MINUTE_W-1:0] minute_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_class_ff;
   logic [NUMBER_W-1:0] out_number_ff;
   logic [MINUTE_W-1:0] out_minute_ff;

   // Decision.
   logic                is_issue, issue_class, full, n_wait, p_wait;
   logic                serve_n, serve_p, pop_any;
   logic [IDX_W-1:0]    iss_head;
   logic [CNT_W-1:0]    iss_count;
   logic [IDX_W:0]      tail_sum;
   logic [IDX_W-1:0]    tail;
   logic [NUMBER_W-1:0] next_ticket;
   logic                wr_n, wr_p;
   logic [ENTRY_W-1:0]  wr_entry, pop_entry;
   logic                rsp_fire;

   assign is_issue    = (func_ff == FUNC_ISSUE_NORMAL) || (func_ff == FUNC_ISSUE_PREF);
   assign issue_class = (func_ff == FUNC_ISSUE_PREF);
   assign iss_head    = issue_class ? p_head_ff : n_head_ff;
   assign iss_count   = issue_class ? p_count_ff : n_count_ff;
   assign full        = (iss_count == DEPTH_CNT);
   assign next_ticket = (issue_class ? p_ticket_ff : n_ticket_ff) + NUMBER_W'(1);

   // Tail is head plus count, wrapped once; count is below the depth here.
   assign tail_sum = {1'b0, iss_head} + {1'b0, iss_count[IDX_W-1:0]};
   assign tail     = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                             : tail_sum[IDX_W-1:0];

   assign n_wait = (n_count_ff != '0);
   assign p_wait = (p_count_ff != '0);

   // Weighted round robin: the weight counter moves only while both wait.
   always_comb begin
      serve_n   = 1'b0;
      serve_p   = 1'b0;
      weight_in = weight_ff;
      if (func_ff == FUNC_CALL) begin
         if (n_wait && p_wait) begin
            if (weight_ff < npp_ff) begin
               serve_n   = 1'b1;
               weight_in = weight_ff + WEIGHT_W'(1);
            end else begin
               serve_p   = 1'b1;
               weight_in = '0;
            end
         end else begin
            serve_n = n_wait;
            serve_p = p_wait;
         end
      end
   end

   assign pop_any  = serve_n || serve_p;
   assign wr_n     = cmd.execute && is_issue && !full && !issue_class;
   assign wr_p     = cmd.execute && is_issue && !full && issue_class;
   assign wr_entry = {next_ticket, minute_ff};
   assign rsp_fire = out_valid_ff && rsp_tready;

   assign stat.nop      = !is_issue && (func_ff != FUNC_CALL);
   assign stat.pops     = pop_any;
   assign stat.out_busy = out_valid_ff;

   // Normal queue memory.
   always_ff @(posedge clock) begin
      if (wr_n) begin
         n_mem[tail] <= wr_entry;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.execute && serve_n) begin
         n_rdata_ff <= n_mem[n_head_ff];
      end
   end

   // Preferential queue memory.
   always_ff @(posedge clock) begin
      if (wr_p) begin
         p_mem[tail] <= wr_entry;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.execute && serve_p) begin
         p_rdata_ff <= p_mem[p_head_ff];
      end
   end

   assign pop_entry = pop_class_ff ? p_rdata_ff : n_rdata_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_head_ff    <= '0;
         p_head_ff    <= '0;
         n_count_ff   <= '0;
         p_count_ff   <= '0;
         n_ticket_ff  <= '0;
         p_ticket_ff  <= '0;
         weight_ff    <= '0;
         npp_ff       <= WEIGHT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            npp_ff <= csr_wr_data;
         end
         if (wr_n) begin
            n_count_ff  <= n_count_ff + CNT_W'(1);
            n_ticket_ff <= next_ticket;
         end
         if (wr_p) begin
            p_count_ff  <= p_count_ff + CNT_W'(1);
            p_ticket_ff <= next_ticket;
         end
         if (cmd.execute && serve_n) begin
            n_count_ff <= n_count_ff - CNT_W'(1);
            n_head_ff  <= (n_head_ff == LAST_IDX) ? '0 : n_head_ff + IDX_W'(1);
         end
         if (cmd.execute && serve_p) begin
            p_count_ff <= p_count_ff - CNT_W'(1);
            p_head_ff  <= (p_head_ff == LAST_IDX) ? '0 : p_head_ff + IDX_W'(1);
         end
         if (cmd.execute) begin
            weight_ff <= weight_in;
         end
         if ((cmd.execute && !pop_any) || cmd.load_fetch) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         minute_ff <= req_minute;
      end
      if (cmd.execute) begin
         pop_class_ff <= serve_p;
         if (is_issue) begin
            out_class_ff <= issue_class;
            if (full) begin
               out_status_ff <= STATUS_FULL;
               out_number_ff <= '0;
               out_minute_ff <= '0;
            end else begin
               out_status_ff <= STATUS_ISSUED;
               out_number_ff <= next_ticket;
               out_minute_ff <= minute_ff;
            end
         end else if (!pop_any) begin
            out_status_ff <= STATUS_NONE;
            out_class_ff  <= CLASS_NORMAL;
            out_number_ff <= '0;
            out_minute_ff <= '0;
         end
      end
      if (cmd.load_fetch) begin
         out_status_ff <= STATUS_CALLED;
         out_class_ff  <= pop_class_ff;
         out_number_ff <= pop_entry[ENTRY_W-1:MINUTE_W];
         out_minute_ff <= pop_entry[MINUTE_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_class  = out_class_ff;
   assign rsp_number = out_number_ff;
   assign rsp_minute = out_minute_ff;

   // The fill counts never pass the depth.
   a_n_count_range: assert property (@(posedge clock) disable iff (reset)
      n_count_ff <= DEPTH_CNT) else $error("normal queue count out of range");
   a_p_count_range: assert property (@(posedge clock) disable iff (reset)
      p_count_ff <= DEPTH_CNT) else $error("preferential queue count out of range");

   // A new result is never written over one that still waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(cmd.execute && !pop_any) && !cmd.load_fetch)
      else $error("output register overwritten");

   // A queue entry is read only when that queue holds tickets.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && pop_any) |-> ((serve_n && n_wait) || (serve_p && p_wait)))
      else $error("pop from empty queue");

   // A fetch always follows a pop in the previous cycle.
   a_fetch_after_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.load_fetch |-> $past(cmd.execute && pop_any))
      else $error("fetch without pop");

endmodule

>>> dv/tb_two_queue_weighted_ticket_dispatcher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ticket dispatcher testbench
// Drives issue and call items into the two-queue dispatcher with random
// pacing and stalls on both streams. Every response is checked field by field
// against a behavioral predictor of both queues, the ticket counters and the
// weighted round robin. A short directed sequence comes first, then random
// traffic phases under changing weights, then a back-to-back pass that fills
// both queues, knocks on each full queue and drains them.
// ----------------------------------------------------------------------------
module tb_two_queue_weighted_ticket_dispatcher_unit;
   import tqwtd_pkg::*;

   localparam int QUEUE_DEPTH    = 64;
   localparam int RANDOM_ITEMS   = 340;
   localparam int SETTLE_CYCLES  = 8;     // settling time after the last expected response
   localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

   // The function code the block must ignore.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // One response as the block reports it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                cls;
      logic [NUMBER_W-1:0] number;
      logic [MINUTE_W-1:0] minute;
   } ticket_result_type;

   // One ticket waiting in a queue.
   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [MINUTE_W-1:0] minute;
   } waiting_ticket_type;

   typedef enum {ROW_ITEM, ROW_WEIGHT} row_kind_type;

   // One step of the directed sequence. A row either writes the weight
   // register or sends an item; a fixed row carries its response typed in.
   typedef struct {
      row_kind_type        kind;
      logic [FUNC_W-1:0]   func;
      logic [MINUTE_W-1:0] minute;
      logic [WEIGHT_W-1:0] weight;
      bit                  fixed;
      ticket_result_type   result;
   } plan_row_type;

   typedef enum {MIX_BALANCED, MIX_FILL_NORMAL, MIX_FILL_PREF, MIX_DRAIN} traffic_mix_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata   = '0;   // [10:0] arrival_minute, [15:11] zero
   logic [1:0]          req_tuser   = '0;   // [1:0] func
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [31:0]         rsp_tdata;          // [0] class, [16:1] number, [27:17] minute
   logic [1:0]          rsp_tuser;          // [1:0] status
   logic                csr_wr_en   = 1'b0;
   logic [3:0]          csr_wr_data = WEIGHT_RESET;

   two_queue_weighted_ticket_dispatcher_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor state: both waiting lines, the last number handed out in each
   // class, the weight register and the count of normal tickets the round robin
   // has served since it last chose a preferential one.
   // -------------------------------------------------------------------------
   waiting_ticket_type  normal_line[$];
   waiting_ticket_type  pref_line[$];
   logic [NUMBER_W-1:0] normal_last_number = '0;
   logic [NUMBER_W-1:0] pref_last_number   = '0;
   logic [WEIGHT_W-1:0] weight_reg         = WEIGHT_RESET;
   logic [WEIGHT_W-1:0] normals_this_round = '0;

   ticket_result_type   awaited_responses[$];

   int failures          = 0;
   int responses_checked = 0;
   int status_seen[4]    = '{0, 0, 0, 0};
   int items_accepted    = 0;
   int random_items      = 0;
   int weights_written   = 0;
   int quiet_cycles      = 0;

   // Pacing controls shared between the stimulus and the receiver.
   bit tx_gaps_on      = 1'b1;
   int tx_burst_left   = 0;
   bit rx_stall_on     = 1'b1;
   int rx_hold_request = 0;

   // Works out the response to one accepted item and updates the predicted
   // state. Returns 0 for the unused function code, which has no response.
   function automatic bit predict_dispatch(input logic [FUNC_W-1:0] func,
                                           input logic [MINUTE_W-1:0] minute,
                                           output ticket_result_type res);
      waiting_ticket_type  t;
      logic [NUMBER_W-1:0] number;
      bit                  from_pref;
      res = '0;
      case (func)
         FUNC_ISSUE_NORMAL, FUNC_ISSUE_PREF: begin
            from_pref = (func == FUNC_ISSUE_PREF);
            res.cls   = from_pref ? CLASS_PREF : CLASS_NORMAL;
            if ((from_pref ? pref_line.size() : normal_line.size()) >= QUEUE_DEPTH) begin
               // A full queue rejects the ticket and leaves its counter alone.
               res.status = STATUS_FULL;
            end else begin
               if (from_pref) begin
                  pref_last_number = pref_last_number + 1'b1;
                  number = pref_last_number;
               end else begin
                  normal_last_number = normal_last_number + 1'b1;
                  number = normal_last_number;
               end
               t.number = number;
               t.minute = minute;
               if (from_pref) pref_line.push_back(t);
               else normal_line.push_back(t);
               res.status = STATUS_ISSUED;
               res.number = number;
               res.minute = minute;
            end
            return 1'b1;
         end
         FUNC_CALL: begin
            if (normal_line.size() != 0 && pref_line.size() != 0) begin
               // Round robin only advances while both classes wait.
               if (normals_this_round < weight_reg) begin
                  from_pref = 1'b0;
                  normals_this_round = normals_this_round + 1'b1;
               end else begin
                  from_pref = 1'b1;
                  normals_this_round = '0;
               end
            end else begin
               from_pref = (normal_line.size() == 0);
            end
            if (normal_line.size() == 0 && pref_line.size() == 0) begin
               res.status = STATUS_NONE;
            end else begin
               if (from_pref) t = pref_line.pop_front();
               else t = normal_line.pop_front();
               res.status = STATUS_CALLED;
               res.cls    = from_pref ? CLASS_PREF : CLASS_NORMAL;
               res.number = t.number;
               res.minute = t.minute;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Sender side. Every task starts and ends at a falling edge.
   // -------------------------------------------------------------------------

   // Bursts of random length separated by random gaps.
   task automatic pace_sender();
      if (tx_gaps_on) begin
         if (tx_burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            tx_burst_left = $urandom_range(1, 16);
         end else begin
            tx_burst_left--;
         end
      end
   endtask

   // Offers one item and waits for it to be taken. A fixed response, where
   // given, replaces the predicted one in the expectation store.
   task automatic send_ticket_item(input logic [FUNC_W-1:0] func,
                                   input logic [MINUTE_W-1:0] minute,
                                   input bit use_fixed,
                                   input ticket_result_type fixed_result);
      ticket_result_type predicted;
      req_tuser  <= func;
      req_tdata  <= {5'b0, minute};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (predict_dispatch(func, minute, predicted))
         awaited_responses.push_back(use_fixed ? fixed_result : predicted);
      if (func != FUNC_UNUSED) items_accepted++;
      @(negedge clock);
      pace_sender();
   endtask

   // Stops sending until every expected response has come back, then lets
   // the block settle so that an ignored item cannot still be in flight.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes normal_per_preferential while the block is idle.
   task automatic set_weight(input logic [WEIGHT_W-1:0] value);
      wait_for_responses();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      weight_reg = value;
      weights_written++;
   endtask

   function automatic logic [FUNC_W-1:0] pick_func(input traffic_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return FUNC_UNUSED;
      case (mix)
         MIX_FILL_NORMAL:
            return (r < 80) ? FUNC_ISSUE_NORMAL : (r < 88) ? FUNC_ISSUE_PREF : FUNC_CALL;
         MIX_FILL_PREF:
            return (r < 80) ? FUNC_ISSUE_PREF : (r < 88) ? FUNC_ISSUE_NORMAL : FUNC_CALL;
         MIX_DRAIN:
            return (r < 12) ? FUNC_ISSUE_NORMAL : (r < 24) ? FUNC_ISSUE_PREF : FUNC_CALL;
         default:
            return (r < 36) ? FUNC_ISSUE_NORMAL : (r < 68) ? FUNC_ISSUE_PREF : FUNC_CALL;
      endcase
   endfunction

   // Mostly real minutes of the day, with the edges and the unused upper
   // range mixed in.
   function automatic logic [MINUTE_W-1:0] pick_minute();
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'd1439;
         2:       return 11'($urandom_range(1440, 2047));
         default: return 11'($urandom_range(0, 1439));
      endcase
   endfunction

   function automatic plan_row_type item_row(input logic [FUNC_W-1:0] func,
                                             input logic [MINUTE_W-1:0] minute);
      plan_row_type row;
      row = '{kind: ROW_ITEM, func: func, minute: minute, weight: '0,
              fixed: 1'b0, result: '0};
      return row;
   endfunction

   function automatic plan_row_type fixed_row(input logic [FUNC_W-1:0] func,
                                              input logic [MINUTE_W-1:0] minute,
                                              input logic [STATUS_W-1:0] status,
                                              input logic cls,
                                              input logic [NUMBER_W-1:0] number,
                                              input logic [MINUTE_W-1:0] res_minute);
      plan_row_type row;
      row = item_row(func, minute);
      row.fixed  = 1'b1;
      row.result = '{status: status, cls: cls, number: number, minute: res_minute};
      return row;
   endfunction

   function automatic plan_row_type weight_row(input logic [WEIGHT_W-1:0] value);
      plan_row_type row;
      row = item_row(FUNC_UNUSED, '0);
      row.kind   = ROW_WEIGHT;
      row.weight = value;
      return row;
   endfunction

   // -------------------------------------------------------------------------
   // Receiver side: its own ready/stall pattern, or a long hold-off when the
   // stimulus asks for one.
   // -------------------------------------------------------------------------
   initial begin
      int  hold;
      int  run_left;
      bit  ready_phase;
      run_left    = 0;
      ready_phase = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_request != 0) begin
            hold = rx_hold_request;
            rx_hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else if (!rx_stall_on) begin
            rsp_tready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               ready_phase = !ready_phase;
               run_left = ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            run_left--;
            rsp_tready <= ready_phase;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response checker: each accepted response against the oldest expectation.
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      ticket_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with nothing expected, actual status %0d data 0x%08h",
                     $time, rsp_tuser, rsp_tdata);
            failures++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("status",        want.status, rsp_tuser);
            check_field("ticket_class",  want.cls,    rsp_tdata[0]);
            check_field("ticket_number", want.number, rsp_tdata[16:1]);
            check_field("ticket_minute", want.minute, rsp_tdata[27:17]);
            responses_checked++;
            status_seen[want.status]++;
         end
      end
   end

   // Watchdog: ends the run if no handshake happens on either stream for too
   // long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles, %0d responses outstanding",
                     $time, WATCHDOG_LIMIT, awaited_responses.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      plan_row_type      plan[$];
      traffic_mix_type   mix;
      int                phase;
      int                phase_len;
      logic [FUNC_W-1:0] func;

      // Directed sequence. After reset the weight is 2, so the first calls
      // serve two normal tickets and then one preferential.
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_NONE, CLASS_NORMAL, 16'd0, 11'd0));
      plan.push_back(fixed_row(FUNC_ISSUE_NORMAL, 11'd0,
                               STATUS_ISSUED, CLASS_NORMAL, 16'd1, 11'd0));
      // An out-of-range minute is kept as it is.
      plan.push_back(fixed_row(FUNC_ISSUE_PREF, 11'd2047,
                               STATUS_ISSUED, CLASS_PREF, 16'd1, 11'd2047));
      plan.push_back(fixed_row(FUNC_ISSUE_NORMAL, 11'd1439,
                               STATUS_ISSUED, CLASS_NORMAL, 16'd2, 11'd1439));
      plan.push_back(fixed_row(FUNC_ISSUE_NORMAL, 11'd1440,
                               STATUS_ISSUED, CLASS_NORMAL, 16'd3, 11'd1440));
      plan.push_back(fixed_row(FUNC_ISSUE_PREF, 11'd1,
                               STATUS_ISSUED, CLASS_PREF, 16'd2, 11'd1));
      // The unused function code must leave no trace.
      plan.push_back(item_row(FUNC_UNUSED, 11'd2047));
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_CALLED, CLASS_NORMAL, 16'd1, 11'd0));
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_CALLED, CLASS_NORMAL, 16'd2, 11'd1439));
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_CALLED, CLASS_PREF, 16'd1, 11'd2047));
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_CALLED, CLASS_NORMAL, 16'd3, 11'd1440));
      // Only the preferential queue is left, so it is served regardless.
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_CALLED, CLASS_PREF, 16'd2, 11'd1));
      plan.push_back(fixed_row(FUNC_CALL, 11'd0, STATUS_NONE, CLASS_NORMAL, 16'd0, 11'd0));
      // With a weight of zero every call prefers the preferential queue.
      plan.push_back(weight_row(4'd0));
      plan.push_back(item_row(FUNC_ISSUE_NORMAL, 11'd100));
      plan.push_back(item_row(FUNC_ISSUE_PREF, 11'd101));
      plan.push_back(item_row(FUNC_ISSUE_PREF, 11'd102));
      plan.push_back(item_row(FUNC_CALL, 11'd0));
      plan.push_back(item_row(FUNC_CALL, 11'd0));
      plan.push_back(item_row(FUNC_CALL, 11'd0));
      // Build up the round count under the top weight, then lower the
      // weight below it: the next shared call must go preferential.
      plan.push_back(weight_row(4'd15));
      plan.push_back(item_row(FUNC_ISSUE_NORMAL, 11'd200));
      plan.push_back(item_row(FUNC_ISSUE_NORMAL, 11'd201));
      plan.push_back(item_row(FUNC_ISSUE_NORMAL, 11'd202));
      plan.push_back(item_row(FUNC_ISSUE_PREF, 11'd203));
      plan.push_back(item_row(FUNC_CALL, 11'd0));
      plan.push_back(item_row(FUNC_CALL, 11'd0));
      plan.push_back(weight_row(4'd1));
      plan.push_back(item_row(FUNC_CALL, 11'd0));
      plan.push_back(item_row(FUNC_CALL, 11'd0));

      // Hold reset, then release it on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WEIGHT)
            set_weight(plan[i].weight);
         else
            send_ticket_item(plan[i].func, plan[i].minute, plan[i].fixed, plan[i].result);
      end

      // Random traffic in phases. The first four phases set fixed weights, among
      // them both extremes, and steer the queues to full and back to empty; later
      // phases pick everything at random. Queue contents carry over between phases.
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0:       begin set_weight(4'd1);  mix = MIX_BALANCED;    end
            1:       begin set_weight(4'd15); mix = MIX_FILL_NORMAL; end
            2:       begin set_weight(4'd0);  mix = MIX_FILL_PREF;   end
            3:       begin set_weight(4'd7);  mix = MIX_DRAIN;       end
            default: begin
               set_weight(4'($urandom_range(0, 15)));
               mix = traffic_mix_type'($urandom_range(0, 3));
            end
         endcase
         tx_gaps_on  = (phase == 0) || ($urandom_range(0, 3) != 0);
         rx_stall_on = (phase == 0) || ($urandom_range(0, 3) != 0);
         phase_len   = (mix == MIX_BALANCED) ? $urandom_range(60, 90) : $urandom_range(90, 120);
         for (int i = 0; i < phase_len; i++) begin
            // One long receiver hold-off while the sender keeps offering, so
            // the block backs up and drops its input ready.
            if (phase == 1 && i == 10) rx_hold_request = LONG_HOLD;
            func = pick_func(mix);
            send_ticket_item(func, pick_minute(), 1'b0, '0);
            if (func != FUNC_UNUSED) random_items++;
         end
         phase++;
      end

      // Back-to-back pass: fill both queues to the brim, knock once on each
      // full queue, then drain everything and make one call on the empty
      // block. No pacing here, so the block runs at its own rate.
      set_weight(4'd3);
      tx_gaps_on  = 1'b0;
      rx_stall_on = 1'b0;
      while (normal_line.size() < QUEUE_DEPTH)
         send_ticket_item(FUNC_ISSUE_NORMAL, pick_minute(), 1'b0, '0);
      while (pref_line.size() < QUEUE_DEPTH)
         send_ticket_item(FUNC_ISSUE_PREF, pick_minute(), 1'b0, '0);
      send_ticket_item(FUNC_ISSUE_NORMAL, pick_minute(), 1'b0, '0);
      send_ticket_item(FUNC_ISSUE_PREF, pick_minute(), 1'b0, '0);
      repeat (normal_line.size() + pref_line.size() + 1)
         send_ticket_item(FUNC_CALL, '0, 1'b0, '0);

      // Drain what is left and let the block go quiet.
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d random) under %0d weight settings; checked %0d responses.",
               items_accepted, random_items, weights_written, responses_checked);
      $display("Responses: %0d issued, %0d called, %0d empty calls, %0d full rejects.",
               status_seen[STATUS_ISSUED], status_seen[STATUS_CALLED],
               status_seen[STATUS_NONE], status_seen[STATUS_FULL]);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
